// ===== rtl/core/stack_machine_arithmetic_unit_core_defines.svh =====
// Assertion macros for the stack machine arithmetic unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef STACK_MACHINE_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define STACK_MACHINE_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define SMAU_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define SMAU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/smau_pkg.sv =====
// Shared types, codes and helper functions for the stack machine arithmetic unit.
// Used by every module of the block but smau_ram; depends on nothing.
package smau_pkg;

  localparam int DATA_W            = 32;
  localparam int MODE_W            = 3;
  localparam int STATUS_W          = 3;
  localparam int STACK_DEPTH_DEF   = 256;
  localparam int FRACTION_BITS_DEF = 16;

  // Instruction codes
  typedef enum logic [MODE_W-1:0] {
    MODE_RETURN = 3'd0,
    MODE_PUSH   = 3'd1,
    MODE_NEGATE = 3'd2,
    MODE_ADD    = 3'd3,
    MODE_SUB    = 3'd4,
    MODE_MUL    = 3'd5,
    MODE_DIV    = 3'd6
  } mode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_RETURNED  = 3'd1,
    STAT_UNDERFLOW = 3'd2,
    STAT_OVERFLOW  = 3'd3,
    STAT_DIVZERO   = 3'd4
  } status_t;

  // How the stack changes when the instruction retires
  typedef enum logic [1:0] {
    CLS_NONE,  // stack untouched
    CLS_PUSH,  // spill top, load constant, depth + 1
    CLS_TOS,   // replace top
    CLS_POP    // replace top with result, depth - 1
  } cls_t;

  // Which execution path the instruction takes after decode
  typedef enum logic [1:0] {
    PATH_SIMPLE,
    PATH_MUL,
    PATH_DIV
  } path_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_MUL_SAT,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_SAT,
    S_DONE
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
    logic mul;
    logic mul_sat;
    logic div_init;
    logic div_step;
    logic div_sat;
    logic commit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    path_t path;
  } sts_t;

  // Quotient bits the divider produces: the dividend is 32 + f bits wide,
  // anything needing more than 33 bits saturates anyway.
  function automatic int div_steps(input int f);
    div_steps = (DATA_W + f < DATA_W + 1) ? DATA_W + f : DATA_W + 1;
  endfunction

  // Saturate a 33-bit signed sum to 32 bits
  function automatic logic [DATA_W-1:0] sat33(input logic [DATA_W:0] s);
    if (s[DATA_W] != s[DATA_W-1]) begin
      sat33 = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat33 = s[DATA_W-1:0];
    end
  endfunction

  // Apply a sign to an unsigned magnitude and saturate
  function automatic logic [DATA_W-1:0] sat_mag(input logic [63:0] mag, input logic neg);
    logic big;
    big = (mag[63:DATA_W-1] != '0);
    if (neg) begin
      sat_mag = big ? {1'b1, {(DATA_W-1){1'b0}}} : (~mag[DATA_W-1:0] + DATA_W'(1));
    end else begin
      sat_mag = big ? {1'b0, {(DATA_W-1){1'b1}}} : mag[DATA_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/stack_machine_arithmetic_unit_core.sv =====
// Stack machine arithmetic unit: one bytecode instruction per transaction, one result each.
// Steps accept to result: decode; multiply and saturate for multiply; for divide, setup,
// min(32 + FRACTION_BITS, 33) quotient bits at one a cycle (33 at Q16.16) and saturate;
// then retire. Throughput: one instruction in flight, the next taken the cycle after the
// previous retires; a stalled result holds retire back.
// Synchronous active-low reset empties the stack; stack RAM contents are not cleared.
module stack_machine_arithmetic_unit_core #(
  parameter int STACK_DEPTH   = smau_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = smau_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [smau_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [smau_pkg::DATA_W-1:0]  in_constant_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [smau_pkg::DATA_W-1:0]  out_top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]    out_stack_depth,
  output logic [smau_pkg::STATUS_W-1:0]       out_status
);

  smau_pkg::cmd_t cmd;
  smau_pkg::sts_t sts;

  // Sequencer
  smau_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Stack and arithmetic
  smau_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_mode),
    .in_constant_value (in_constant_value),
    .out_top_value     (out_top_value),
    .out_stack_depth   (out_stack_depth),
    .out_status        (out_status)
  );

endmodule

// ===== rtl/core/smau_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependencies.
module smau_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/smau_ctrl.sv =====
// Controller FSM: sequences decode, multiply, iterative divide and retire.
// Depends on smau_pkg and the assertion macro header.
`include "stack_machine_arithmetic_unit_core_defines.svh"

module smau_ctrl #(
  parameter int FRACTION_BITS = smau_pkg::FRACTION_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output smau_pkg::cmd_t  cmd,
  input  smau_pkg::sts_t  sts
);

  localparam int QB = smau_pkg::div_steps(FRACTION_BITS);
  localparam int CW = $clog2(QB);
  localparam logic [CW-1:0] CNT_LAST = CW'(QB - 1);

  smau_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smau_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      smau_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = smau_pkg::S_EXEC;
        end
      end
      smau_pkg::S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.path)
          smau_pkg::PATH_MUL: state_nxt = smau_pkg::S_MUL;
          smau_pkg::PATH_DIV: state_nxt = smau_pkg::S_DIV_INIT;
          default:            state_nxt = smau_pkg::S_DONE;
        endcase
      end
      smau_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = smau_pkg::S_MUL_SAT;
      end
      smau_pkg::S_MUL_SAT: begin
        cmd.mul_sat = 1'b1;
        state_nxt   = smau_pkg::S_DONE;
      end
      smau_pkg::S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = smau_pkg::S_DIV_STEP;
      end
      smau_pkg::S_DIV_STEP: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = smau_pkg::S_DIV_SAT;
        end
      end
      smau_pkg::S_DIV_SAT: begin
        cmd.div_sat = 1'b1;
        state_nxt   = smau_pkg::S_DONE;
      end
      smau_pkg::S_DONE: begin
        // retire once the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = smau_pkg::S_IDLE;
        end
      end
      default: state_nxt = smau_pkg::S_IDLE;
    endcase
  end

  // Output valid: set on retire, held while the consumer stalls
  assign out_valid_nxt = cmd.commit || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;

  `SMAU_ASSERT_NEXT(a_accept_to_exec, clk, rst_n, in_valid && !in_stall,
    state_r == smau_pkg::S_EXEC, "accepted transaction did not enter decode")
  `SMAU_ASSERT_NOW(a_commit_room, clk, rst_n, cmd.commit,
    !out_valid_r || !out_stall, "retire would overwrite a pending result")
  `SMAU_ASSERT_NEXT(a_div_len, clk, rst_n,
    state_r == smau_pkg::S_DIV_STEP && cnt_r == CNT_LAST,
    state_r == smau_pkg::S_DIV_SAT, "divide did not end after last quotient bit")

endmodule

// ===== rtl/core/smau_dp.sv =====
// Datapath: top-of-stack register, stack RAM, adder, multiplier, divider, output regs.
// Depends on smau_pkg, smau_ram and the assertion macro header.
`include "stack_machine_arithmetic_unit_core_defines.svh"

module smau_dp #(
  parameter int STACK_DEPTH   = smau_pkg::STACK_DEPTH_DEF,
  parameter int FRACTION_BITS = smau_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smau_pkg::cmd_t                      cmd,
  output smau_pkg::sts_t                      sts,
  input  logic [smau_pkg::MODE_W-1:0]         in_mode,
  input  logic signed [smau_pkg::DATA_W-1:0]  in_constant_value,
  output logic signed [smau_pkg::DATA_W-1:0]  out_top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]    out_stack_depth,
  output logic [smau_pkg::STATUS_W-1:0]       out_status
);

  localparam int DW  = smau_pkg::DATA_W;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int QB  = smau_pkg::div_steps(FRACTION_BITS);
  localparam int NW  = DW + FRACTION_BITS;  // divide dividend width
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  // Transaction and stack state
  logic [smau_pkg::MODE_W-1:0] mode_r;
  logic [DW-1:0]               cval_r;
  logic [SPW-1:0]              sp_r, sp_nxt;
  logic [DW-1:0]               tos_r, tos_nxt;
  smau_pkg::status_t           status_r;
  smau_pkg::cls_t              cls_r;
  logic [DW-1:0]               res_r;

  // Arithmetic state
  logic [DW-1:0]   mag_n_r, mag_t_r;
  logic            neg_r;
  logic [63:0]     prod_r;
  logic [DW-1:0]   rem_r;
  logic [QB-1:0]   dvd_r;
  logic [QB-1:0]   quo_r;
  logic            dovf_r;

  // Output registers
  logic [DW-1:0]              out_top_r;
  logic [SPW-1:0]             out_depth_r;
  logic [smau_pkg::STATUS_W-1:0] out_status_r;

  // RAM holds every entry below the top of stack
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_rdata;

  assign ram_raddr = AW'(sp_r - SPW'(2));
  assign ram_waddr = AW'(sp_r - SPW'(1));
  assign ram_we    = cmd.commit && (cls_r == smau_pkg::CLS_PUSH) && (sp_r != '0);

  smau_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (tos_r),
    .re    (cmd.load),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Decode and single-cycle operations
  logic [DW-1:0]     n_val, t_val, neg_res, mag_n_e, mag_t_e;
  logic [DW:0]       sum_e, diff_e;
  logic              sp_ge1, sp_ge2, sp_full;
  smau_pkg::status_t status_e;
  smau_pkg::cls_t    cls_e;
  smau_pkg::path_t   path_e;
  logic [DW-1:0]     res_e;

  assign n_val   = ram_rdata;
  assign t_val   = tos_r;
  assign sp_ge1  = (sp_r != '0);
  assign sp_ge2  = (sp_r > SPW'(1));
  assign sp_full = (sp_r == SP_FULL);
  assign sum_e   = {n_val[DW-1], n_val} + {t_val[DW-1], t_val};
  assign diff_e  = {n_val[DW-1], n_val} - {t_val[DW-1], t_val};
  assign neg_res = (t_val == {1'b1, {(DW-1){1'b0}}}) ? {1'b0, {(DW-1){1'b1}}}
                                                     : (~t_val + DW'(1));
  assign mag_n_e = n_val[DW-1] ? (~n_val + DW'(1)) : n_val;
  assign mag_t_e = t_val[DW-1] ? (~t_val + DW'(1)) : t_val;

  always_comb begin
    status_e = smau_pkg::STAT_OK;
    cls_e    = smau_pkg::CLS_NONE;
    path_e   = smau_pkg::PATH_SIMPLE;
    res_e    = sum_e[DW-1:0];
    case (mode_r)
      smau_pkg::MODE_RETURN: begin
        status_e = smau_pkg::STAT_RETURNED;
      end
      smau_pkg::MODE_PUSH: begin
        if (sp_full) begin
          status_e = smau_pkg::STAT_OVERFLOW;
        end else begin
          cls_e = smau_pkg::CLS_PUSH;
        end
      end
      smau_pkg::MODE_NEGATE: begin
        if (!sp_ge1) begin
          status_e = smau_pkg::STAT_UNDERFLOW;
        end else begin
          cls_e = smau_pkg::CLS_TOS;
          res_e = neg_res;
        end
      end
      smau_pkg::MODE_ADD, smau_pkg::MODE_SUB: begin
        if (!sp_ge2) begin
          status_e = smau_pkg::STAT_UNDERFLOW;
        end else begin
          cls_e = smau_pkg::CLS_POP;
          res_e = smau_pkg::sat33((mode_r == smau_pkg::MODE_ADD) ? sum_e : diff_e);
        end
      end
      smau_pkg::MODE_MUL: begin
        if (!sp_ge2) begin
          status_e = smau_pkg::STAT_UNDERFLOW;
        end else begin
          cls_e  = smau_pkg::CLS_POP;
          path_e = smau_pkg::PATH_MUL;
        end
      end
      smau_pkg::MODE_DIV: begin
        if (!sp_ge2) begin
          status_e = smau_pkg::STAT_UNDERFLOW;
        end else if (t_val == '0) begin
          status_e = smau_pkg::STAT_DIVZERO;
        end else begin
          cls_e  = smau_pkg::CLS_POP;
          path_e = smau_pkg::PATH_DIV;
        end
      end
      default: begin
        // undefined code: no operation
      end
    endcase
  end

  assign sts.path = path_e;

  // Divider setup: quotients of 2^QB or more saturate, so only QB bits iterate
  logic [NW-1:0] dvd_full, dvd_hi;
  logic [DW:0]   trial;
  logic          trial_ge;

  assign dvd_full = NW'(mag_n_r) << FRACTION_BITS;
  assign dvd_hi   = dvd_full >> QB;
  assign trial    = {rem_r, dvd_r[QB-1]};
  assign trial_ge = (trial >= {1'b0, mag_t_r});

  // Instruction capture, execute and arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      cval_r <= in_constant_value;
    end
    if (cmd.exec) begin
      status_r <= status_e;
      cls_r    <= cls_e;
      res_r    <= res_e;
      mag_n_r  <= mag_n_e;
      mag_t_r  <= mag_t_e;
      neg_r    <= n_val[DW-1] ^ t_val[DW-1];
    end
    if (cmd.mul) begin
      prod_r <= 64'(mag_n_r) * 64'(mag_t_r);
    end
    if (cmd.mul_sat) begin
      res_r <= smau_pkg::sat_mag(prod_r >> FRACTION_BITS, neg_r);
    end
    if (cmd.div_init) begin
      dovf_r <= (dvd_hi >= NW'(mag_t_r));
      rem_r  <= dvd_hi[DW-1:0];
      dvd_r  <= dvd_full[QB-1:0];
      quo_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= trial_ge ? DW'(trial - {1'b0, mag_t_r}) : trial[DW-1:0];
      dvd_r <= dvd_r << 1;
      quo_r <= {quo_r[QB-2:0], trial_ge};
    end
    if (cmd.div_sat) begin
      res_r <= smau_pkg::sat_mag(dovf_r ? {64{1'b1}} : 64'(quo_r), neg_r);
    end
  end

  // Retire: next top and depth
  always_comb begin
    sp_nxt  = sp_r;
    tos_nxt = tos_r;
    case (cls_r)
      smau_pkg::CLS_PUSH: begin
        sp_nxt  = sp_r + SPW'(1);
        tos_nxt = cval_r;
      end
      smau_pkg::CLS_TOS: begin
        tos_nxt = res_r;
      end
      smau_pkg::CLS_POP: begin
        sp_nxt  = sp_r - SPW'(1);
        tos_nxt = res_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (cmd.commit) begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      tos_r        <= tos_nxt;
      out_top_r    <= (sp_nxt == '0) ? '0 : tos_nxt;
      out_depth_r  <= sp_nxt;
      out_status_r <= status_r;
    end
  end

  assign out_top_value   = out_top_r;
  assign out_stack_depth = out_depth_r;
  assign out_status      = out_status_r;

  `SMAU_ASSERT_NOW(a_push_room, clk, rst_n, cmd.commit && cls_r == smau_pkg::CLS_PUSH,
    sp_r != SP_FULL, "push retired on a full stack")
  `SMAU_ASSERT_NOW(a_pop_depth, clk, rst_n, cmd.commit && cls_r == smau_pkg::CLS_POP,
    sp_r > SPW'(1), "binary operation retired with fewer than two entries")

endmodule
